FILE: src/lpd_pkg.sv
// Shared types, constants and register map for the lighthouse pulse decoder.
`timescale 1ns / 1ps

package lpd_pkg;

    // Defaults for top-level parameters
    localparam int STAMP_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Sweep values are kept as 16-bit words
    localparam int SWEEP_BITS = 16;

    // Register map (index = paddr[3:2])
    localparam int CFG_ADDR_BITS = 4;
    typedef enum logic [1:0] {
        REG_MIN_INTERVAL  = 2'd0,
        REG_SYNC_INTERVAL = 2'd1,
        REG_SYNC_LIMIT    = 2'd2
    } reg_index_t;

    localparam logic [14:0] MIN_INTERVAL_RST  = 15'd500;
    localparam logic [14:0] SYNC_INTERVAL_RST = 15'd8000;
    localparam logic [1:0]  SYNC_LIMIT_RST    = 2'd3;

    // Frame tags
    localparam logic [7:0] TAG_X0  = 8'h21;  // '!'
    localparam logic [7:0] TAG_Y0  = 8'h40;  // '@'
    localparam logic [7:0] TAG_X1  = 8'h23;  // '#'
    localparam logic [7:0] TAG_Y1  = 8'h24;  // '$'
    localparam logic [7:0] TAG_END = 8'h7E;  // '~'

    localparam logic [3:0] FRAME_LAST_BYTE = 4'd12;

    typedef struct packed {
        logic [14:0] min_interval;
        logic [14:0] sync_interval;
        logic [1:0]  sync_limit;
    } cfg_t;

    // One position frame: both receivers' sweep values
    typedef struct packed {
        logic [SWEEP_BITS-1:0] x0;
        logic [SWEEP_BITS-1:0] y0;
        logic [SWEEP_BITS-1:0] x1;
        logic [SWEEP_BITS-1:0] y1;
    } frame_t;

    // Front-end status seen by the top level
    typedef struct packed {
        logic [1:0] ready_mark;
        logic       frame_push;
    } front_status_t;

endpackage

FILE: src/lighthouse_pulse_decoder.sv
// Top level of the lighthouse sweep pulse decoder: register port and block wiring.
//
//  Channel  Dir  Handshake              Word contents
//  s_*      in   s_tvalid/s_tready      tuser: receiver; tdata: capture_stamp
//  m_*      out  m_tvalid/m_tready      tdata: frame_byte; tlast: frame_end
//  APB      in   psel/penable, pready=1 min_interval, sync_interval, sync_limit
//
//  One capture word is taken every cycle while the frame queue has room;
//  decode is a combinational subtract, compare and flag update in the front end.
//  Each frame leaves as 13 words, one per cycle while m_tready is high, from
//  the serialiser; QUEUE_DEPTH frames may wait behind it before s_tready drops.
//  rst_n is asynchronous, active low; it clears all control state and loads
//  the register defaults. Sweep values are not reset.
`timescale 1ns / 1ps

module lighthouse_pulse_decoder
    import lpd_pkg::*;
#(
    parameter int STAMP_BITS  = STAMP_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    // capture stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [((STAMP_BITS+7)/8)*8-1:0]    s_tdata,   // [STAMP_BITS-1:0] capture_stamp
    input  logic                               s_tuser,   // [0] receiver
    // frame stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [7:0]                         m_tdata,   // [7:0] frame_byte
    output logic                               m_tlast,
    // register port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [CFG_ADDR_BITS-1:0]           paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    cfg_t          cfg_reg;
    logic          cfg_wr;
    reg_index_t    reg_idx;

    logic          s_acc;
    logic          push;
    frame_t        push_frame;
    front_status_t front_st;
    frame_t        q_data;
    logic          q_full;
    logic          q_not_empty;
    logic          pop;

    // ---------------- register port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = reg_index_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_interval  <= MIN_INTERVAL_RST;
            cfg_reg.sync_interval <= SYNC_INTERVAL_RST;
            cfg_reg.sync_limit    <= SYNC_LIMIT_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_MIN_INTERVAL:  cfg_reg.min_interval  <= pwdata[14:0];
                REG_SYNC_INTERVAL: cfg_reg.sync_interval <= pwdata[14:0];
                REG_SYNC_LIMIT:    cfg_reg.sync_limit    <= pwdata[1:0];
                default:           ;  // unmapped: ignored
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_MIN_INTERVAL:  prdata = 32'(cfg_reg.min_interval);
            REG_SYNC_INTERVAL: prdata = 32'(cfg_reg.sync_interval);
            REG_SYNC_LIMIT:    prdata = 32'(cfg_reg.sync_limit);
            default:           prdata = '0;
        endcase
    end

    // ---------------- datapath ----------------
    // Input held off only while the queue is full, frame or not.
    assign s_tready = !q_full;
    assign s_acc    = s_tvalid && s_tready;

    lpd_front #(
        .STAMP_BITS (STAMP_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .accept   (s_acc),
        .receiver (s_tuser),
        .stamp    (s_tdata[STAMP_BITS-1:0]),
        .push     (push),
        .frame    (push_frame),
        .status   (front_st)
    );

    lpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_data   (push_frame),
        .pop       (pop),
        .rd_data   (q_data),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    lpd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_data      (q_data),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

`ifndef NO_ASSERTIONS
    // A frame is never pushed into a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        front_st.frame_push |-> !q_full)
        else $error("frame pushed into full queue");

    // Ready marks are cleared as soon as both are set
    assert property (@(posedge clk) disable iff (!rst_n)
        !(front_st.ready_mark[0] && front_st.ready_mark[1]))
        else $error("both ready marks left set");

    // The closing word of a frame is always the tilde
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tdata == TAG_END))
        else $error("frame end without closing tag");

    // After the closing word is taken, a new frame starts only from the queue
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast && !q_not_empty) |=> !m_tvalid)
        else $error("serialiser busy with no frame queued");
`endif

endmodule

FILE: src/lpd_front.sv
// Front end: per-receiver interval decode and sweep sequencing.
`timescale 1ns / 1ps

module lpd_front
    import lpd_pkg::*;
#(
    parameter int STAMP_BITS = STAMP_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic                  accept,
    input  logic                  receiver,
    input  logic [STAMP_BITS-1:0] stamp,
    output logic                  push,
    output frame_t                frame,
    output front_status_t         status
);

    logic [1:0]            awaiting_reg, awaiting_next;
    logic [STAMP_BITS-1:0] prev_reg [2];
    logic [STAMP_BITS-1:0] prev_next [2];
    logic [1:0]            sync_cnt_reg [2];
    logic [1:0]            sync_cnt_next [2];
    logic [1:0]            x_reg, x_next;
    logic [1:0]            y_reg, y_next;
    logic [1:0]            rdy_reg, rdy_next;
    logic [SWEEP_BITS-1:0] xval_reg [2];
    logic [SWEEP_BITS-1:0] xval_next [2];
    logic [SWEEP_BITS-1:0] yval_reg [2];
    logic [SWEEP_BITS-1:0] yval_next [2];

    logic [STAMP_BITS-1:0] diff;
    logic [31:0]           ival;
    logic [1:0]            rdy_upd;

    always_comb
    begin
        awaiting_next = awaiting_reg;
        prev_next     = prev_reg;
        sync_cnt_next = sync_cnt_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        xval_next     = xval_reg;
        yval_next     = yval_reg;
        rdy_upd       = rdy_reg;
        diff          = stamp - prev_reg[receiver];
        ival          = 32'(diff[STAMP_BITS-1:1]);

        if (accept)
        begin
            if (awaiting_reg[receiver])
            begin
                prev_next[receiver]     = stamp;
                awaiting_next[receiver] = 1'b0;
            end
            else if (ival > 32'(cfg.min_interval))
            begin
                prev_next[receiver] = stamp;
                if (ival > 32'(cfg.sync_interval))
                begin
                    if (sync_cnt_reg[receiver] < cfg.sync_limit)
                    begin
                        sync_cnt_next[receiver] = sync_cnt_reg[receiver] + 2'd1;
                        x_next[receiver]        = 1'b1;
                        y_next[receiver]        = 1'b0;
                    end
                end
                else if (sync_cnt_reg[receiver] != 2'd0)
                begin
                    if (x_reg[receiver] && !y_reg[receiver])
                    begin
                        xval_next[receiver] = ival[SWEEP_BITS-1:0];
                        y_next[receiver]    = 1'b1;
                    end
                    else if (x_reg[receiver] && y_reg[receiver])
                    begin
                        x_next[receiver] = 1'b0;  // gap
                    end
                    else if (!x_reg[receiver] && y_reg[receiver])
                    begin
                        yval_next[receiver]     = ival[SWEEP_BITS-1:0];
                        rdy_upd[receiver]       = 1'b1;
                        y_next[receiver]        = 1'b0;
                        sync_cnt_next[receiver] = 2'd0;
                    end
                end
            end
        end

        // Both ready: hand a frame to the queue and clear the marks
        push     = rdy_upd[0] && rdy_upd[1];
        rdy_next = push ? 2'b00 : rdy_upd;
        frame.x0 = xval_next[0];
        frame.y0 = yval_next[0];
        frame.x1 = xval_next[1];
        frame.y1 = yval_next[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg <= 2'b11;
            prev_reg     <= '{default: '0};
            sync_cnt_reg <= '{default: '0};
            x_reg        <= '0;
            y_reg        <= '0;
            rdy_reg      <= '0;
        end
        else
        begin
            awaiting_reg <= awaiting_next;
            prev_reg     <= prev_next;
            sync_cnt_reg <= sync_cnt_next;
            x_reg        <= x_next;
            y_reg        <= y_next;
            rdy_reg      <= rdy_next;
        end
    end

    // Sweep values need no reset
    always_ff @(posedge clk)
    begin
        xval_reg <= xval_next;
        yval_reg <= yval_next;
    end

    assign status.ready_mark = rdy_reg;
    assign status.frame_push = push;

endmodule

FILE: src/lpd_queue.sv
// Short frame queue between decode front end and byte serialiser.
`timescale 1ns / 1ps

module lpd_queue
    import lpd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  frame_t wr_data,
    input  logic   pop,
    output frame_t rd_data,
    output logic   full,
    output logic   not_empty
);

    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

    frame_t              slot_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == CNT_FULL);
    assign not_empty = (cnt_reg != '0);
    assign rd_data   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: src/lpd_back.sv
// Back end: serialises one queued frame into 13 output words.
`timescale 1ns / 1ps

module lpd_back
    import lpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_not_empty,
    input  frame_t     q_data,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast
);

    frame_t     frame_reg;
    logic       busy_reg, busy_next;
    logic [3:0] idx_reg, idx_next;
    logic       last_byte;
    logic       out_acc;

    assign last_byte = (idx_reg == FRAME_LAST_BYTE);
    assign out_acc   = busy_reg && m_tready;
    assign pop       = q_not_empty && (!busy_reg || (out_acc && last_byte));

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (pop)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (out_acc)
        begin
            if (last_byte)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            frame_reg <= q_data;
        end
    end

    // Byte order: value low, value high, tag; closing tilde
    always_comb
    begin
        case (idx_reg)
            4'd0:    m_tdata = frame_reg.x0[7:0];
            4'd1:    m_tdata = frame_reg.x0[15:8];
            4'd2:    m_tdata = TAG_X0;
            4'd3:    m_tdata = frame_reg.y0[7:0];
            4'd4:    m_tdata = frame_reg.y0[15:8];
            4'd5:    m_tdata = TAG_Y0;
            4'd6:    m_tdata = frame_reg.x1[7:0];
            4'd7:    m_tdata = frame_reg.x1[15:8];
            4'd8:    m_tdata = TAG_X1;
            4'd9:    m_tdata = frame_reg.y1[7:0];
            4'd10:   m_tdata = frame_reg.y1[15:8];
            4'd11:   m_tdata = TAG_Y1;
            default: m_tdata = TAG_END;
        endcase
    end

    assign m_tvalid = busy_reg;
    assign m_tlast  = last_byte;

endmodule
